>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion helpers
// Short forms for clocked assertions, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define LKV_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");

// Clocked assertion that also holds across reset.
`define LKV_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed: %m");

`endif

>>> hdl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg - shared types and constants for the LRU key/value cache
// Word formats, command codes, register map and the entry record of a cell.
// ----------------------------------------------------------------------------
package lkv_pkg;

   localparam int KEY_BITS     = 32;
   localparam int VALUE_BITS   = 32;
   localparam int ENTRIES_DEF  = 16;
   localparam int CAP_BITS     = 5;
   localparam int CAP_RESET    = 16;
   localparam int PADDR_BITS   = 3;
   localparam int PDATA_BITS   = 32;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_SET = 1'b1;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef struct packed {
      logic                  command;
      logic [KEY_BITS-1:0]   lookup_key;
      logic [VALUE_BITS-1:0] write_value;
   } req_word_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } rsp_word_type;

   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage

>>> hdl/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell - one recency slot of the cache chain
// Holds one entry, compares it against the probe key, and takes the entry of
// its left neighbor when told to shift.
// ----------------------------------------------------------------------------
module lkv_cell
   import lkv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  entry_type           left,
   input  logic [KEY_BITS-1:0] probe_key,
   output entry_type           q,
   output logic                match
);

   logic                  valid_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= left.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         key_ff   <= left.key;
         value_ff <= left.value;
      end
   end

   assign q     = '{valid: valid_ff, key: key_ff, value: value_ff};
   assign match = valid_ff && (key_ff == probe_key);

endmodule

>>> hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache - fully associative key/value store, LRU replacement
// Recency-ordered chain of cells with a compare/update sequence.
// ----------------------------------------------------------------------------
// Each request word passes a compare step and an update step: the key is
// compared against every cell at the edge that accepts the word, and the
// chain shift plus the response register load happen at the update edge that
// follows, once the response register is free; req_stall is high from the
// accept until that update edge. The response sits in an output register, so
// a new request is taken while an older response waits on rsp_stall; an update
// waits only when the response register is still full. Cells are kept in recency order: cell 0
// is the most recent entry, the last valid cell the least recent. A hit
// moves its entry to cell 0 and shifts the cells in front of it back by one;
// a new key enters at cell 0 and shifts all valid cells back, dropping the
// tail cell when the store is at capacity. Capacity is the register value
// clamped to 1..ENTRIES. Writing the capacity register (byte addresses 0..3)
// empties the store at once; writes elsewhere are ignored. Reads there return
// the register, other reads return zero. The store is empty after reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [PDATA_BITS-1:0] pwdata,
   output logic [PDATA_BITS-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

   // ---- register port ----
   logic                csr_write;
   logic [CAP_BITS-1:0] cap_ff, cap_in;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_IDX_CAPACITY);
   assign cap_in    = pwdata[CAP_BITS-1:0];
   assign prdata    = (paddr[2] == CSR_IDX_CAPACITY) ? PDATA_BITS'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_BITS'(CAP_RESET);
      end else if (csr_write) begin
         cap_ff <= cap_in;
      end
   end

   // effective capacity, clamped to 1..ENTRIES
   logic [CMP_W-1:0] cap_ext, cap_eff;

   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   // ---- cell chain ----
   entry_type              cell_q    [ENTRIES];
   entry_type              cell_left [ENTRIES];
   cell_ctrl_type          cell_ctrl [ENTRIES];
   logic [ENTRIES-1:0]     match_now;
   logic [ENTRIES-1:0]     shift_en;
   entry_type              front;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign cell_left[g] = front;
      end else begin : g_body
         assign cell_left[g] = cell_q[g-1];
      end

      assign cell_ctrl[g] = '{clear: csr_write, shift: shift_en[g]};

      lkv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl[g]),
         .left      (cell_left[g]),
         .probe_key (req_data.lookup_key),
         .q         (cell_q[g]),
         .match     (match_now[g])
      );
   end

   // ---- compare stage: request captured with the match vector ----
   logic               busy_ff, busy_in;
   req_word_type       req_ff;
   logic [ENTRIES-1:0] match_ff;
   logic               accept;
   logic               update;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff   <= req_data;
         match_ff <= match_now;
      end
   end

   // ---- update stage ----
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic                  hit_any;
   logic                  is_set;
   logic                  full;
   logic [IDX_W-1:0]      hit_idx;
   logic [IDX_W-1:0]      shift_lim;
   logic [VALUE_BITS-1:0] hit_value;
   logic [KEY_BITS-1:0]   tail_key;
   logic                  do_evict;
   logic                  do_move;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_data_ff, rsp_data_in;

   assign update  = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign hit_any = |match_ff;
   assign is_set  = (req_ff.command == CMD_SET);
   assign full    = CMP_W'(occ_ff) >= cap_eff;

   // at most one cell matches: OR-combine instead of a priority search
   always_comb begin
      hit_idx   = '0;
      hit_value = '0;
      tail_key  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_ff[i]) begin
            hit_idx   = hit_idx | IDX_W'(i);
            hit_value = hit_value | cell_q[i].value;
         end
         if (CNT_W'(i + 1) == occ_ff) begin
            tail_key = tail_key | cell_q[i].key;
         end
      end
   end

   // last cell that takes its left neighbor
   always_comb begin
      priority if (hit_any) begin
         shift_lim = hit_idx;
      end else if (full) begin
         shift_lim = IDX_W'(occ_ff - CNT_W'(1));
      end else begin
         shift_lim = IDX_W'(occ_ff);
      end
   end

   assign do_move  = update && (hit_any || is_set);
   assign do_evict = is_set && !hit_any && full;

   assign front = '{valid: 1'b1,
                    key:   req_ff.lookup_key,
                    value: is_set ? req_ff.write_value : hit_value};

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         shift_en[i] = do_move && (IDX_W'(i) <= shift_lim);
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (csr_write) begin
         occ_in = '0;
      end else if (update && is_set && !hit_any && !full) begin
         occ_in = occ_ff + CNT_W'(1);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (update) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (update) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_data_in = '{hit:         hit_any,
                          read_value:  (hit_any && !is_set) ? hit_value : '0,
                          evicted:     do_evict,
                          evicted_key: do_evict ? tail_key : '0};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker - port-level assertions for the LRU key/value cache
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkv_checker
   import lkv_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // a held response keeps its word
   `LKV_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // one word at a time: the cycle after a request is taken the port stalls
   `LKV_ASSERT(a_req_one_cycle_stall, clock, reset, req_take |=> req_stall)

   // with the response register empty, the answer shows once the word has passed the compare and update steps
   `LKV_ASSERT(a_rsp_latency, clock, reset, req_take && !rsp_valid |-> ##2 rsp_valid)

   // reset leaves no response pending
   `LKV_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
